>>> hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`endif

>>> hdl/ndr_pkg.sv
// package: fixed field widths and register reset value
package ndr_pkg;
   localparam int MAXD_WIDTH = 25;
   localparam int PDIST_WIDTH = 25;
   localparam logic [MAXD_WIDTH-1:0] MAXD_RESET = 25'd65536;
   localparam longint FLOOR_NUM = 9999;
   localparam longint FLOOR_DEN = 10000;

   typedef logic [MAXD_WIDTH-1:0] maxd_type;
endpackage

>>> hdl/normalized_distance_reward_2d.sv
// top level: normalized 2d distance reward pipeline
// throughput: one request per cycle, busy is always low
// the depth is set by the square root (one bit per stage) and the divider (one bit per stage)
// synchronous reset clears all valid bits and sets max_distance to 1.0
module normalized_distance_reward_2d #(
   parameter int COORD_WIDTH = 24,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [COORD_WIDTH-1:0] req_box_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_y,
   input  logic signed [COORD_WIDTH-1:0] req_target_x,
   input  logic signed [COORD_WIDTH-1:0] req_target_y,
   input  logic                        csr_write_enable,
   input  logic [ndr_pkg::MAXD_WIDTH-1:0] csr_write_data,
   output logic                        rsp_strobe,
   output logic [FRAC_BITS:0]          rsp_reward,
   output logic [ndr_pkg::PDIST_WIDTH-1:0] rsp_point_distance
);
   localparam int CW = COORD_WIDTH;
   localparam int SQ_W = 2 * CW + 1;
   localparam int RT_W = CW + 1;
   localparam int DW = ((RT_W > ndr_pkg::MAXD_WIDTH) ? RT_W : ndr_pkg::MAXD_WIDTH) + 1;
   localparam longint FLOOR_L =
      ((64'sd1 << FRAC_BITS) + ndr_pkg::FLOOR_NUM) / ndr_pkg::FLOOR_DEN;
   localparam logic [RT_W-1:0] DIST_FLOOR = RT_W'(FLOOR_L);
   localparam int SIDE_W = RT_W + 1;

   ndr_pkg::maxd_type max_distance_ff;

   logic [CW-1:0]   dx_ff, dy_ff;
   logic            a_valid_ff;
   logic [2*CW-1:0] sqx_ff, sqy_ff;
   logic            b_valid_ff;
   logic [SQ_W-1:0] sum_ff;
   logic            c_valid_ff;

   logic            root_valid;
   logic [RT_W-1:0] root;

   logic [RT_W-1:0] dist_in;
   logic [RT_W-1:0] dist_ff;
   logic            sat_ff;
   logic            d_valid_ff;

   logic [DW-1:0]   div_rem;
   logic [DW-1:0]   div_divisor;
   logic            div_valid;
   logic [FRAC_BITS-1:0] div_quot;
   logic [SIDE_W-1:0] div_side;

   logic signed [CW:0] diff_x, diff_y;

   logic [FRAC_BITS:0] reward_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff <= ndr_pkg::MAXD_RESET;
      end else if (csr_write_enable) begin
         max_distance_ff <= csr_write_data;
      end
   end

   // stage a: absolute differences
   assign diff_x = {req_target_x[CW-1], req_target_x} - {req_box_x[CW-1], req_box_x};
   assign diff_y = {req_target_y[CW-1], req_target_y} - {req_box_y[CW-1], req_box_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= root_valid;
      end
      dx_ff  <= diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
      dy_ff  <= diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];
      // stage b: squares
      sqx_ff <= dx_ff * dx_ff;
      sqy_ff <= dy_ff * dy_ff;
      // stage c: sum of squares
      sum_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
   end

   ndr_sqrt #(.IN_W(SQ_W), .OUT_W(RT_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_rad    (sum_ff),
      .out_valid (root_valid),
      .out_root  (root)
   );

   // stage d: distance floor and saturation check
   assign dist_in = (root < DIST_FLOOR) ? DIST_FLOOR : root;

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      sat_ff  <= DW'(dist_in) >= DW'(max_distance_ff);
   end

   assign div_rem     = sat_ff ? '0 : DW'(dist_ff);
   assign div_divisor = DW'(max_distance_ff);

   ndr_div #(.DW(DW), .STEPS(FRAC_BITS), .SIDE_W(SIDE_W)) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (d_valid_ff),
      .in_rem     (div_rem),
      .in_divisor (div_divisor),
      .in_side    ({sat_ff, dist_ff}),
      .out_valid  (div_valid),
      .out_quot   (div_quot),
      .out_side   (div_side)
   );

   // stage e: reward and result register
   assign reward_in = div_side[RT_W] ? '0
                    : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, div_quot});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= div_valid;
      end
      rsp_reward         <= reward_in;
      rsp_point_distance <= ndr_pkg::PDIST_WIDTH'(div_side[RT_W-1:0]);
   end
endmodule

>>> hdl/ndr_sqrt.sv
// pipelined integer square root, one result bit per stage
module ndr_sqrt #(
   parameter int IN_W = 49,
   parameter int OUT_W = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [IN_W-1:0]  in_rad,
   output logic             out_valid,
   output logic [OUT_W-1:0] out_root
);
   localparam int RW = 2 * OUT_W;

   logic [RW-1:0]    rem_ff   [OUT_W];
   logic [OUT_W-1:0] root_ff  [OUT_W];
   logic             valid_ff [OUT_W];

   for (genvar g = 0; g < OUT_W; g++) begin : g_stage
      localparam int B = OUT_W - 1 - g;
      logic [RW-1:0]    rem_prev;
      logic [RW-1:0]    delta;
      logic [OUT_W-1:0] root_prev;
      logic             valid_prev;
      logic             take;

      if (g == 0) begin : g_first
         assign rem_prev   = {{(RW-IN_W){1'b0}}, in_rad};
         assign root_prev  = '0;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[g-1];
         assign root_prev  = root_ff[g-1];
         assign valid_prev = valid_ff[g-1];
      end

      assign delta = ({{(RW-OUT_W){1'b0}}, root_prev} << (B + 1))
                   | ({{(RW-1){1'b0}}, 1'b1} << (2 * B));
      assign take  = rem_prev >= delta;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= valid_prev;
         end
         rem_ff[g]  <= take ? rem_prev - delta : rem_prev;
         root_ff[g] <= take ? (root_prev | ({{(OUT_W-1){1'b0}}, 1'b1} << B)) : root_prev;
      end
   end

   assign out_valid = valid_ff[OUT_W-1];
   assign out_root  = root_ff[OUT_W-1];
endmodule

>>> hdl/ndr_div.sv
// pipelined restoring divider for a fraction below one, one quotient bit per stage
module ndr_div #(
   parameter int DW = 26,
   parameter int STEPS = 16,
   parameter int SIDE_W = 26
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DW-1:0]     in_rem,
   input  logic [DW-1:0]     in_divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [STEPS-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);
   logic [DW-1:0]     rem_ff   [STEPS];
   logic [STEPS-1:0]  quot_ff  [STEPS];
   logic [SIDE_W-1:0] side_ff  [STEPS];
   logic              valid_ff [STEPS];

   for (genvar g = 0; g < STEPS; g++) begin : g_stage
      logic [DW-1:0]     rem_prev;
      logic [DW-1:0]     rem_dbl;
      logic [STEPS-1:0]  quot_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;
      logic              take;

      if (g == 0) begin : g_first
         assign rem_prev   = in_rem;
         assign quot_prev  = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[g-1];
         assign quot_prev  = quot_ff[g-1];
         assign side_prev  = side_ff[g-1];
         assign valid_prev = valid_ff[g-1];
      end

      assign rem_dbl = {rem_prev[DW-2:0], 1'b0};
      assign take    = rem_dbl >= in_divisor;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= valid_prev;
         end
         rem_ff[g]  <= take ? rem_dbl - in_divisor : rem_dbl;
         quot_ff[g] <= {quot_prev[STEPS-2:0], take};
         side_ff[g] <= side_prev;
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_quot  = quot_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];
endmodule

>>> hdl/ndr_checker.sv
// checker on the top level ports, with its bind
`include "assert_macros.svh"

module ndr_checker #(
   parameter int COORD_WIDTH = 24,
   parameter int FRAC_BITS = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_strobe,
   input logic [FRAC_BITS:0]              rsp_reward,
   input logic [ndr_pkg::PDIST_WIDTH-1:0] rsp_point_distance
);
   localparam int LAT = 5 + COORD_WIDTH + 1 + FRAC_BITS;
   localparam longint FLOOR_L =
      ((64'sd1 << FRAC_BITS) + ndr_pkg::FLOOR_NUM) / ndr_pkg::FLOOR_DEN;
   localparam logic [ndr_pkg::PDIST_WIDTH-1:0] DIST_FLOOR =
      ndr_pkg::PDIST_WIDTH'(FLOOR_L);
   localparam logic [FRAC_BITS:0] REWARD_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   `ASSERT_NEVER(a_never_busy, clock, reset, busy)
   `ASSERT_IMP(a_latency, clock, reset, rsp_strobe, $past(start, LAT))
   `ASSERT_IMP(a_reward_max, clock, reset, rsp_strobe, rsp_reward <= REWARD_ONE)
   `ASSERT_IMP(a_dist_floor, clock, reset, rsp_strobe, rsp_point_distance >= DIST_FLOOR)
endmodule

bind normalized_distance_reward_2d ndr_checker #(
   .COORD_WIDTH (COORD_WIDTH),
   .FRAC_BITS   (FRAC_BITS)
) u_ndr_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_reward         (rsp_reward),
   .rsp_point_distance (rsp_point_distance)
);

>>> tb/testbench.sv
// testbench for the normalized 2d distance reward block: random and directed requests
`timescale 1ns / 100ps

module testbench;
   localparam int CW = 24;
   localparam int FB = 16;
   localparam int LATENCY = 46;

   typedef struct {
      logic [FB:0] reward;
      logic [ndr_pkg::PDIST_WIDTH-1:0] point_dist;
   } reward_result_type;

   class reward_scoreboard_type;
      ndr_pkg::maxd_type max_dist;
      reward_result_type pending[$];
      int errors;
      int checked;

      function new();
         max_dist = ndr_pkg::MAXD_RESET;
         errors = 0;
         checked = 0;
      endfunction

      function void note_request(logic signed [CW-1:0] bx, logic signed [CW-1:0] by,
                                 logic signed [CW-1:0] tx, logic signed [CW-1:0] ty);
         longint dx, dy;
         logic [67:0] sq, cand;
         logic [33:0] root;
         logic [33:0] floor_val;
         longint one, quot;
         reward_result_type r;
         dx = longint'(tx) - longint'(bx);
         dy = longint'(ty) - longint'(by);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         sq = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy);
         root = '0;
         for (int b = 33; b >= 0; b--) begin
            cand = 68'(root | (34'd1 << b));
            if (cand * cand <= sq) root = root | (34'd1 << b);
         end
         floor_val = 34'(((64'd1 << FB) + ndr_pkg::FLOOR_NUM) / ndr_pkg::FLOOR_DEN);
         if (root < floor_val) root = floor_val;
         one = longint'(1) << FB;
         if (max_dist == 0) r.reward = '0;
         else begin
            quot = (longint'(root) << FB) / longint'(max_dist);
            r.reward = (quot >= one) ? '0 : (FB+1)'(one - quot);
         end
         r.point_dist = root[ndr_pkg::PDIST_WIDTH-1:0];
         pending.push_back(r);
      endfunction

      function void check_result(logic [FB:0] reward,
                                 logic [ndr_pkg::PDIST_WIDTH-1:0] point_dist);
         reward_result_type e;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            $error("unexpected result reward=%0d point_distance=%0d", reward, point_dist);
            return;
         end
         e = pending.pop_front();
         if (reward !== e.reward) begin
            errors++;
            $error("reward expected %0d actual %0d", e.reward, reward);
         end
         if (point_dist !== e.point_dist) begin
            errors++;
            $error("point_distance expected %0d actual %0d", e.point_dist, point_dist);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [CW-1:0] req_box_x = '0, req_box_y = '0, req_target_x = '0, req_target_y = '0;
   logic csr_write_enable = 0;
   logic [ndr_pkg::MAXD_WIDTH-1:0] csr_write_data = '0;
   logic rsp_strobe;
   logic [FB:0] rsp_reward;
   logic [ndr_pkg::PDIST_WIDTH-1:0] rsp_point_distance;

   reward_scoreboard_type sb = new();
   int sent = 0;

   always #4 clock = ~clock;

   normalized_distance_reward_2d #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_box_x(req_box_x), .req_box_y(req_box_y),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_strobe(rsp_strobe), .rsp_reward(rsp_reward),
      .rsp_point_distance(rsp_point_distance)
   );

   always @(posedge clock)
      if (!reset && rsp_strobe) sb.check_result(rsp_reward, rsp_point_distance);

   task automatic send_request(logic signed [CW-1:0] bx, logic signed [CW-1:0] by,
                               logic signed [CW-1:0] tx, logic signed [CW-1:0] ty);
      start <= 1;
      req_box_x <= bx;
      req_box_y <= by;
      req_target_x <= tx;
      req_target_y <= ty;
      do @(posedge clock); while (busy);
      sb.note_request(bx, by, tx, ty);
      sent++;
   endtask

   task automatic idle_burst();
      start <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clock);
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_max(ndr_pkg::maxd_type v);
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.max_dist = v;
   endtask

   function automatic logic signed [CW-1:0] rand_coord(int span);
      case ($urandom_range(0, 3))
         0: return CW'($urandom);
         1: return CW'($signed($urandom_range(0, 2 * span)) - span);
         2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
         default: return CW'($signed($urandom_range(0, 64)) - 32);
      endcase
   endfunction

   task automatic random_phase(int n, int span, bit gaps);
      logic signed [CW-1:0] bx, by, tx;
      for (int i = 0; i < n; i++) begin
         bx = rand_coord(span);
         by = rand_coord(span);
         if ($urandom_range(0, 3) == 0) begin
            tx = CW'(int'(bx) + int'($urandom_range(0, 20)) - 10);
            send_request(bx, by, tx, by);
         end
         else send_request(bx, by, rand_coord(span), rand_coord(span));
         if (gaps && $urandom_range(0, 5) == 0) idle_burst();
      end
   endtask

   initial begin
      ndr_pkg::maxd_type max_values[6];
      max_values = '{25'd1, 25'h1ffffff, 25'd65536, 25'd7, 25'd0, 25'd1000000};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes and special cases at the reset maximum
      send_request(0, 0, 0, 0);
      send_request(24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000);
      send_request(24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff);
      send_request(0, 0, 24'sd65536, 0);
      send_request(0, 0, 0, 24'sd32768);
      send_request(0, 0, 24'sd3, 24'sd3);
      send_request(24'sh7fffff, 0, 24'sh800000, 0);
      send_request(-24'sd1, -24'sd1, 24'sd1, 24'sd1);
      send_request(24'sh555555, 24'shaaaaaa, 24'shaaaaaa, 24'sh555555);
      send_request(0, 0, 24'sd100000, 0);
      drain();
      foreach (max_values[k]) begin
         write_max(max_values[k]);
         send_request(0, 0, 24'sd7, 0);
         send_request(0, 0, 24'sd65535, 0);
         send_request(24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff);
         random_phase(200, 200000, 1);
         drain();
      end
      write_max(25'd131072);
      random_phase(570, 8388607, 0);
      drain();
      $display("covered %0d requests over %0d max distance settings, %0d results checked",
               sent, 7, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end
endmodule

>>> files.f
+incdir+hdl
hdl/ndr_pkg.sv
hdl/ndr_sqrt.sv
hdl/ndr_div.sv
hdl/normalized_distance_reward_2d.sv
hdl/ndr_checker.sv
tb/testbench.sv
